### hdl/sdmd_pkg.sv
// shared types, constants and helper functions for the sigma-delta motion detector
// no dependencies; imported by sdmd_pipe, the top level and the testbench
package sdmd_pkg;

  localparam int unsigned MAX_PIXELS = 131072;
  localparam int unsigned PIX_IDX_W  = $clog2(MAX_PIXELS);
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned AMP_W      = 4;
  localparam int unsigned PROD_W     = PIX_W + AMP_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned RAM_W      = 2 * PIX_W;

  localparam logic [AMP_W-1:0] AMP_RESET  = AMP_W'(4);
  localparam logic [PIX_W-1:0] VMIN_RESET = PIX_W'(1);
  localparam logic [PIX_W-1:0] VMAX_RESET = PIX_W'(254);
  localparam logic [PIX_W-1:0] AMP_SAT    = PIX_W'(255);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DETECT = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMP_FACTOR = 2'd0,
    CFG_VAR_MIN    = 2'd1,
    CFG_VAR_MAX    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    op_e                  op;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [PIX_W-1:0]     pixel;
  } in_req_t;

  typedef struct packed {
    logic             motion;
    logic [PIX_W-1:0] mean_out;
    logic [PIX_W-1:0] var_out;
  } out_rsp_t;

  typedef struct packed {
    logic [AMP_W-1:0] amp_factor;
    logic [PIX_W-1:0] var_min;
    logic [PIX_W-1:0] var_max;
  } cfg_t;

  // one unit toward the target, no move when equal
  function automatic logic [PIX_W-1:0] step_toward(input logic [PIX_W-1:0] cur,
                                                   input logic [PIX_W-1:0] tgt);
    logic [PIX_W-1:0] res;
    res = cur;
    if (cur < tgt) begin
      res = cur + PIX_W'(1);
    end else if (cur > tgt) begin
      res = cur - PIX_W'(1);
    end
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] res;
    res = (a > b) ? (a - b) : (b - a);
    return res;
  endfunction

endpackage

### hdl/sdmd_ram.sv
// generic simple dual-port ram: one write port, one read port with registered data
// no package dependencies
module sdmd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while rd_en_i is low
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/sdmd_pipe.sv
// four-stage datapath: mean update, amplification, variance update, output register
// depends on sdmd_pkg; reads and writes the pixel state ram owned by the top level
module sdmd_pipe
  import sdmd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 in_valid_i,
  input  in_req_t              in_req_i,
  input  logic [RAM_W-1:0]     ram_rdata_i,
  input  cfg_t                 cfg_i,
  output logic                 wr_en_o,
  output logic [PIX_IDX_W-1:0] wr_addr_o,
  output logic [RAM_W-1:0]     wr_data_o,
  output logic                 out_valid_o,
  output out_rsp_t             out_rsp_o
);

  typedef struct packed {
    op_e                  op;
    logic [PIX_IDX_W-1:0] idx;
    logic [PIX_W-1:0]     m_new;
    logic [PIX_W-1:0]     diff;
    logic [PIX_W-1:0]     v_old;
  } s2_t;

  typedef struct packed {
    op_e                  op;
    logic [PIX_IDX_W-1:0] idx;
    logic [PIX_W-1:0]     m_new;
    logic [PIX_W-1:0]     diff;
    logic [PIX_W-1:0]     amp;
    logic [PIX_W-1:0]     v_old;
  } s3_t;

  logic                 s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  in_req_t              s1_q;
  s2_t                  s2_q, s2_d;
  s3_t                  s3_q, s3_d;
  out_rsp_t             s4_q, s4_d;
  logic [PIX_IDX_W-1:0] s4_idx_q;

  logic [PIX_W-1:0]  ram_mean, ram_var;
  logic [PIX_W-1:0]  m_fwd, v_fwd1;
  logic [PROD_W-1:0] amp_prod;
  logic [PIX_W-1:0]  v_step, v_new3;
  logic              hit3_s1, hit4_s1;

  assign ram_mean = ram_rdata_i[RAM_W-1:PIX_W];
  assign ram_var  = ram_rdata_i[PIX_W-1:0];

  // variance result of the item leaving stage 3 (it is written this edge unless the pipeline stalls)
  always_comb begin
    v_step = step_toward(s3_q.v_old, s3_q.amp);
    if (v_step > cfg_i.var_max) begin
      v_step = cfg_i.var_max;
    end
    if (v_step < cfg_i.var_min) begin
      v_step = cfg_i.var_min;
    end
    v_new3 = (s3_q.op == OP_LOAD) ? cfg_i.var_min : v_step;
  end

  assign hit3_s1 = s3_valid_q && (s3_q.idx == s1_q.pixel_index);
  assign hit4_s1 = s4_valid_q && (s4_idx_q == s1_q.pixel_index);

  // mean of older in-flight items to the same pixel, youngest first
  always_comb begin
    priority if (s2_valid_q && (s2_q.idx == s1_q.pixel_index)) begin
      m_fwd = s2_q.m_new;
    end else if (hit3_s1) begin
      m_fwd = s3_q.m_new;
    end else if (hit4_s1) begin
      m_fwd = s4_q.mean_out;
    end else begin
      m_fwd = ram_mean;
    end
  end

  // variance is only needed in stage 3, so it is patched by each write as it happens
  always_comb begin
    priority if (hit3_s1) begin
      v_fwd1 = v_new3;
    end else if (hit4_s1) begin
      v_fwd1 = s4_q.var_out;
    end else begin
      v_fwd1 = ram_var;
    end
  end

  always_comb begin
    s2_d.op    = s1_q.op;
    s2_d.idx   = s1_q.pixel_index;
    s2_d.m_new = (s1_q.op == OP_LOAD) ? s1_q.pixel : step_toward(m_fwd, s1_q.pixel);
    s2_d.diff  = abs_diff(s2_d.m_new, s1_q.pixel);
    s2_d.v_old = v_fwd1;
  end

  assign amp_prod = PROD_W'(cfg_i.amp_factor) * PROD_W'(s2_q.diff);

  always_comb begin
    s3_d.op    = s2_q.op;
    s3_d.idx   = s2_q.idx;
    s3_d.m_new = s2_q.m_new;
    s3_d.diff  = s2_q.diff;
    s3_d.amp   = (amp_prod > PROD_W'(AMP_SAT)) ? AMP_SAT : amp_prod[PIX_W-1:0];
    s3_d.v_old = (s3_valid_q && (s3_q.idx == s2_q.idx)) ? v_new3 : s2_q.v_old;
  end

  always_comb begin
    s4_d.mean_out = s3_q.m_new;
    s4_d.var_out  = v_new3;
    s4_d.motion   = (s3_q.op == OP_DETECT) && (s3_q.diff >= v_new3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q     <= in_req_i;
      s2_q     <= s2_d;
      s3_q     <= s3_d;
      s4_q     <= s4_d;
      s4_idx_q <= s3_q.idx;
    end
  end

  assign wr_en_o     = adv_i && s3_valid_q;
  assign wr_addr_o   = s3_q.idx;
  assign wr_data_o   = {s3_q.m_new, v_new3};
  assign out_valid_o = s4_valid_q;
  assign out_rsp_o   = s4_q;

`ifndef ASSERT_OFF
  a_var_in_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (cfg_i.var_min <= cfg_i.var_max)) |->
      ((out_rsp_o.var_out >= cfg_i.var_min) && (out_rsp_o.var_out <= cfg_i.var_max)))
    else $error("variance result outside clamp range");

  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && s3_valid_q && (s3_q.op == OP_LOAD)) |=>
      (!out_rsp_o.motion && (out_rsp_o.var_out == $past(cfg_i.var_min))))
    else $error("load request produced motion or wrong variance");

  a_mean_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && s1_valid_q && (s1_q.op == OP_DETECT)) |=>
      ((s2_q.m_new == $past(m_fwd)) || (s2_q.m_new == $past(m_fwd) + PIX_W'(1)) ||
       (s2_q.m_new == $past(m_fwd) - PIX_W'(1))))
    else $error("mean moved by more than one step");

  a_write_matches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |=> (out_valid_o && (out_rsp_o.mean_out == $past(wr_data_o[RAM_W-1:PIX_W]))))
    else $error("written mean differs from reported mean");
`endif

endmodule

### hdl/sigma_delta_motion_detect.sv
// top level of the sigma-delta motion detector: configuration registers, state ram, flow control
// depends on sdmd_pkg, sdmd_ram and sdmd_pipe
//
// usage:
//   input channel in_valid_i / in_stall_o / in_req_i carries one pixel request per cycle
//   while in_stall_o is low: op (load or detect), pixel_index and the grey level.
//   output channel out_valid_o / out_stall_i / out_rsp_o returns one result per request,
//   in order: motion flag, updated mean and updated variance.
//   configuration registers (amp_factor, var_min, var_max) are written through
//   cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i; the user must write them only
//   while no request is in flight, as the block does not enforce this; cfg_ready_o is
//   always high and unknown indexes are ignored. throughput is one request per cycle
//   while the receiver does not stall, including back-to-back requests to the same pixel,
//   set by the single read port and single write port of the per-pixel state ram.
//   per-pixel mean and variance live in one 131072 x 16 ram whose contents are undefined
//   after reset; every pixel must be loaded before it is detected. reset clears the
//   pipeline and returns the registers to amp_factor 4, var_min 1, var_max 254.
//   while the receiver stalls a waiting result the whole pipeline holds and in_stall_o
//   is raised; nothing is dropped or repeated.
module sigma_delta_motion_detect
  import sdmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_req_t               in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_rsp_t              out_rsp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t                 cfg_q, cfg_d;
  logic                 adv;
  logic                 wr_en;
  logic [PIX_IDX_W-1:0] wr_addr;
  logic [RAM_W-1:0]     wr_data;
  logic [RAM_W-1:0]     rd_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_AMP_FACTOR: cfg_d.amp_factor = cfg_data_i[AMP_W-1:0];
        CFG_VAR_MIN:    cfg_d.var_min    = cfg_data_i[PIX_W-1:0];
        CFG_VAR_MAX:    cfg_d.var_max    = cfg_data_i[PIX_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amp_factor <= AMP_RESET;
      cfg_q.var_min    <= VMIN_RESET;
      cfg_q.var_max    <= VMAX_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // the pipeline moves as one unless the output holds a result the receiver refuses
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  sdmd_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_PIXELS)
  ) u_state_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (adv),
    .rd_addr_i(in_req_i.pixel_index),
    .rd_data_o(rd_data)
  );

  sdmd_pipe u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .ram_rdata_i(rd_data),
    .cfg_i      (cfg_q),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .out_valid_o(out_valid_o),
    .out_rsp_o  (out_rsp_o)
  );

endmodule

### dv/tb_sigma_delta_motion_detect.sv
`timescale 1ns / 100ps
// self-checking testbench for sigma_delta_motion_detect: directed table, then random pixel bursts
// depends on sdmd_pkg and the block's rtl; keeps its own per-pixel background model
module tb_sigma_delta_motion_detect;
  import sdmd_pkg::*;

  localparam int unsigned LAT_CYC   = 4;
  localparam int unsigned CYC_LIMIT = 400000;
  localparam int unsigned N_PHASES  = 8;
  localparam int unsigned PHASE_REQ = 175;
  localparam int unsigned POOL_SZ   = 20;
  localparam int unsigned PIX_TOP   = 255;

  typedef enum bit {
    ROW_PIXEL,
    ROW_REG
  } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    in_req_t               req;
    bit                    typed;
    out_rsp_t              rsp;
    cfg_reg_e              reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_req_t               in_req_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_rsp_t              out_rsp_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // background model: per-pixel mean and variance, plus register copies
  logic [PIX_W-1:0] bg_mean [bit [PIX_IDX_W-1:0]];
  logic [PIX_W-1:0] bg_var  [bit [PIX_IDX_W-1:0]];
  logic [AMP_W-1:0] amp_gain  = AMP_RESET;
  logic [PIX_W-1:0] vclamp_lo = VMIN_RESET;
  logic [PIX_W-1:0] vclamp_hi = VMAX_RESET;

  out_rsp_t             pending_rsp[$];
  dir_row_t             dir_rows[$];
  logic [PIX_IDX_W-1:0] idx_pool[POOL_SZ];

  int unsigned send_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned cyc_cnt = 0;
  int unsigned px_sent = 0;

  sigma_delta_motion_detect u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYC_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] nudge(logic [PIX_W-1:0] cur, logic [PIX_W-1:0] tgt);
    if (cur < tgt) return cur + 1'b1;
    if (cur > tgt) return cur - 1'b1;
    return cur;
  endfunction

  // one load or detect step on the background model
  function automatic out_rsp_t bg_update(in_req_t req);
    out_rsp_t         rsp;
    logic [PIX_W-1:0] m_prev;
    logic [PIX_W-1:0] v_prev;
    logic [PIX_W-1:0] m_nxt;
    logic [PIX_W-1:0] v_nxt;
    logic [PIX_W-1:0] abs_dev;
    int unsigned      gained;
    bit               in_range;
    in_range = req.pixel_index < MAX_PIXELS;
    m_prev = (in_range && bg_mean.exists(req.pixel_index)) ? bg_mean[req.pixel_index] : '0;
    v_prev = (in_range && bg_var.exists(req.pixel_index)) ? bg_var[req.pixel_index] : '0;
    rsp.motion = 1'b0;
    if (req.op == OP_LOAD) begin
      m_nxt = req.pixel;
      v_nxt = vclamp_lo;
    end else begin
      m_nxt = nudge(m_prev, req.pixel);
      abs_dev = (m_nxt > req.pixel) ? m_nxt - req.pixel : req.pixel - m_nxt;
      gained = amp_gain * abs_dev;
      if (gained > PIX_TOP) gained = PIX_TOP;
      v_nxt = nudge(v_prev, PIX_W'(gained));
      // upper clamp first so var_min wins when the clamps cross
      if (v_nxt > vclamp_hi) v_nxt = vclamp_hi;
      if (v_nxt < vclamp_lo) v_nxt = vclamp_lo;
      rsp.motion = (abs_dev >= v_nxt);
    end
    if (in_range) begin
      bg_mean[req.pixel_index] = m_nxt;
      bg_var[req.pixel_index]  = v_nxt;
    end
    rsp.mean_out = m_nxt;
    rsp.var_out  = v_nxt;
    return rsp;
  endfunction

  always @(posedge clk_i) begin : rsp_check
    out_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no pending request: motion=%0d mean_out=%0d var_out=%0d",
               out_rsp_o.motion, out_rsp_o.mean_out, out_rsp_o.var_out);
        err_cnt++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp_o.motion !== want.motion) begin
          $error("motion: expected %0d, got %0d", want.motion, out_rsp_o.motion);
          err_cnt++;
        end
        if (out_rsp_o.mean_out !== want.mean_out) begin
          $error("mean_out: expected %0d, got %0d", want.mean_out, out_rsp_o.mean_out);
          err_cnt++;
        end
        if (out_rsp_o.var_out !== want.var_out) begin
          $error("var_out: expected %0d, got %0d", want.var_out, out_rsp_o.var_out);
          err_cnt++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
  end

  task automatic push_pixel(in_req_t req, bit typed = 1'b0, out_rsp_t typed_rsp = '0);
    out_rsp_t pred;
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = bg_update(req);
    pending_rsp.push_back(typed ? typed_rsp : pred);
    px_sent++;
  endtask

  // valid stays high across back-to-back writes; drain or the next request lowers it
  task automatic reg_write(cfg_reg_e sel, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (sel)
      CFG_AMP_FACTOR: amp_gain = val[AMP_W-1:0];
      CFG_VAR_MIN:    vclamp_lo = val;
      CFG_VAR_MAX:    vclamp_hi = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned amp, int unsigned lo, int unsigned hi);
    reg_write(CFG_AMP_FACTOR, CFG_DATA_W'(amp));
    reg_write(CFG_VAR_MIN, CFG_DATA_W'(lo));
    reg_write(CFG_VAR_MAX, CFG_DATA_W'(hi));
  endtask

  task automatic drain();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (LAT_CYC + 2) @(posedge clk_i);
  endtask

  function automatic void add_px(op_e op, int unsigned idx, int unsigned pix, bit typed = 1'b0,
                                 bit mo = 1'b0, int unsigned mn = 0, int unsigned vr = 0);
    dir_row_t row;
    row.kind            = ROW_PIXEL;
    row.req.op          = op;
    row.req.pixel_index = PIX_IDX_W'(idx);
    row.req.pixel       = PIX_W'(pix);
    row.typed           = typed;
    row.rsp.motion      = mo;
    row.rsp.mean_out    = PIX_W'(mn);
    row.rsp.var_out     = PIX_W'(vr);
    row.reg_sel         = CFG_AMP_FACTOR;
    row.reg_val         = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_reg(cfg_reg_e sel, int unsigned val);
    dir_row_t row;
    row.kind    = ROW_REG;
    row.req     = '0;
    row.typed   = 1'b0;
    row.rsp     = '0;
    row.reg_sel = sel;
    row.reg_val = CFG_DATA_W'(val);
    dir_rows.push_back(row);
  endfunction

  // burst: a stray load, or a base-level load then mostly detects near it on one or two pixels
  task automatic run_burst();
    logic [PIX_IDX_W-1:0] pa;
    logic [PIX_IDX_W-1:0] pb;
    in_req_t              req;
    int                   base;
    int                   p;
    int unsigned          pick;
    int unsigned          len;
    if ($urandom_range(99) < 15) begin
      // stray load anywhere in the frame, sometimes followed by a detect
      req.op          = OP_LOAD;
      req.pixel_index = PIX_IDX_W'($urandom_range(0, MAX_PIXELS - 1));
      req.pixel       = PIX_W'($urandom);
      push_pixel(req);
      if ($urandom_range(1) == 1) begin
        req.op    = OP_DETECT;
        req.pixel = PIX_W'($urandom);
        push_pixel(req);
      end
      return;
    end
    pa   = idx_pool[$urandom_range(0, POOL_SZ - 1)];
    pb   = idx_pool[$urandom_range(0, POOL_SZ - 1)];
    base = $urandom_range(0, PIX_TOP);
    req.op = OP_LOAD;
    if (!bg_mean.exists(pa) || $urandom_range(3) == 0) begin
      req.pixel_index = pa;
      req.pixel       = PIX_W'(base);
      push_pixel(req);
    end
    if (!bg_mean.exists(pb)) begin
      req.pixel_index = pb;
      req.pixel       = PIX_W'(base);
      push_pixel(req);
    end
    len = $urandom_range(2, 24);
    repeat (len) begin
      pick = $urandom_range(99);
      if (pick < 55) p = base + int'($urandom_range(0, 12)) - 6;
      else if (pick < 70) p = base;
      else if (pick < 88) p = $urandom_range(0, PIX_TOP);
      else p = ($urandom_range(1) == 1) ? PIX_TOP : 0;
      if (p < 0) p = 0;
      if (p > PIX_TOP) p = PIX_TOP;
      req.op          = ($urandom_range(99) < 6) ? OP_LOAD : OP_DETECT;
      req.pixel_index = ($urandom_range(99) < 70) ? pa : pb;
      req.pixel       = PIX_W'(p);
      push_pixel(req);
      if ($urandom_range(9) == 0) base = $urandom_range(0, PIX_TOP);
    end
  endtask

  initial begin : stim
    int unsigned phase_end;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_req_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_AMP_FACTOR;
    cfg_data_i  <= '0;

    idx_pool[0] = '0;
    idx_pool[1] = PIX_IDX_W'(MAX_PIXELS - 1);
    for (int i = 2; i < POOL_SZ; i++) begin
      idx_pool[i] = PIX_IDX_W'($urandom_range(0, MAX_PIXELS - 1));
    end

    // directed rows, starting from the reset register values
    add_px(OP_LOAD, 0, 0, 1'b1, 1'b0, 0, 1);
    add_px(OP_LOAD, MAX_PIXELS - 1, PIX_TOP, 1'b1, 1'b0, PIX_TOP, 1);
    add_px(OP_DETECT, 0, PIX_TOP, 1'b1, 1'b1, 1, 2);
    add_px(OP_DETECT, MAX_PIXELS - 1, 0, 1'b1, 1'b1, 254, 2);
    add_px(OP_DETECT, 0, 1);
    add_px(OP_LOAD, 'h15555, 'hAA, 1'b1, 1'b0, 'hAA, 1);
    add_px(OP_DETECT, 'h15555, 'hAA);
    add_px(OP_LOAD, 'h0AAAA, 'h55, 1'b1, 1'b0, 'h55, 1);
    add_px(OP_DETECT, 'h0AAAA, 'h5A);
    // amplification off
    add_reg(CFG_AMP_FACTOR, 0);
    add_px(OP_DETECT, 0, 200);
    // crossed clamps, var_min takes over
    add_reg(CFG_VAR_MIN, 200);
    add_reg(CFG_VAR_MAX, 100);
    add_px(OP_DETECT, MAX_PIXELS - 1, 100);
    add_px(OP_LOAD, 'h0AAAA, 7, 1'b1, 1'b0, 7, 200);
    add_reg(CFG_AMP_FACTOR, 15);
    add_reg(CFG_VAR_MIN, 0);
    add_reg(CFG_VAR_MAX, PIX_TOP);
    add_px(OP_DETECT, 'h15555, 0);
    add_px(OP_DETECT, 'h0AAAA, 7);
    // zero variance band: every detect flags motion
    add_reg(CFG_VAR_MAX, 0);
    add_px(OP_DETECT, 0, 0);
    add_px(OP_DETECT, 'h15555, PIX_TOP);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (i == 0 || dir_rows[i - 1].kind == ROW_PIXEL) drain();
        reg_write(dir_rows[i].reg_sel, dir_rows[i].reg_val);
      end else begin
        push_pixel(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          rcv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 71;
          rcv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          rcv_stall_pct = 71;
        end
        default: begin
          send_idle_pct = 6;
          rcv_stall_pct = 6;
        end
      endcase
      case (ph)
        0: set_regs(1, 0, PIX_TOP);
        1: set_regs(15, PIX_TOP, PIX_TOP);
        2: set_regs(0, 0, 0);
        3: set_regs(8, 200, 10);
        // upper nibble of the amp write is don't-care
        default: set_regs($urandom_range(0, PIX_TOP), $urandom_range(0, 60),
                          $urandom_range(20, PIX_TOP));
      endcase
      phase_end = px_sent + PHASE_REQ;
      while (px_sent < phase_end) run_burst();
    end

    drain();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
